>>> src/nis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nis_pkg;

    localparam int unsigned SQ_STEPS  = 31;   // root bits of a 62-bit radicand
    localparam int unsigned DIV_STEPS = 17;   // quotient bits
    localparam int unsigned NORM_MSB  = 23;   // the largest scaled magnitude lands in [2^23, 2^24)

    localparam logic [15:0] HALF_SCALE = 16'd32768;
    localparam logic [15:0] CHAN_MAX   = 16'd65535;

    typedef struct packed {
        logic signed [15:0] weight_a;
        logic signed [15:0] weight_b;
        logic signed [15:0] weight_c;
        logic signed [15:0] normal_a_x;
        logic signed [15:0] normal_a_y;
        logic signed [15:0] normal_a_z;
        logic signed [15:0] normal_b_x;
        logic signed [15:0] normal_b_y;
        logic signed [15:0] normal_b_z;
        logic signed [15:0] normal_c_x;
        logic signed [15:0] normal_c_y;
        logic signed [15:0] normal_c_z;
    } t_in_word;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        degenerate;
    } t_out_word;

    // per-pixel data that rides along the root and divide stages
    typedef struct packed {
        logic [2:0]        neg;
        logic              zero;
        logic [2:0][23:0]  mag;
    } t_side;

endpackage

`default_nettype wire

>>> src/normal_interpolate_shade.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake        | Word
// --------+-----------+------------------+----------------------------------------
// input   | in        | i_valid/o_stall  | i_word: 3 weights Q2.14, 9 normals Q1.15
// output  | out       | o_valid/i_stall  | o_word: red, green, blue Q0.16, degenerate
//
// Fully pipelined: one pixel word per clock while the output is not stalled.
// Most of the pipeline is the square root (31 stages, one root bit each) and the
// divider (17 stages, one quotient bit each, three lanes in parallel).
// Reset clears only the valid bits; the pipeline is empty after reset.
// A stall on the output with a word waiting freezes every stage at once and
// is passed back on o_stall in the same cycle.

module normal_interpolate_shade
    import nis_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_word  i_word,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_word
);

    logic en;

    // ---------------------------------------------------------------
    // S1: nine 16x16 products
    // ---------------------------------------------------------------
    logic signed [15:0] w [3];
    logic signed [15:0] nv [3][3];   // [vertex][axis]

    assign w[0] = i_word.weight_a;
    assign w[1] = i_word.weight_b;
    assign w[2] = i_word.weight_c;
    assign nv[0][0] = i_word.normal_a_x;
    assign nv[0][1] = i_word.normal_a_y;
    assign nv[0][2] = i_word.normal_a_z;
    assign nv[1][0] = i_word.normal_b_x;
    assign nv[1][1] = i_word.normal_b_y;
    assign nv[1][2] = i_word.normal_b_z;
    assign nv[2][0] = i_word.normal_c_x;
    assign nv[2][1] = i_word.normal_c_y;
    assign nv[2][2] = i_word.normal_c_z;

    logic               r1_valid;
    logic signed [31:0] r1_p [3][3];  // [axis][vertex]

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                for (int v = 0; v < 3; v++) begin
                    r1_p[a][v] <= w[v] * nv[v][a];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // S2: blend sums, sign and magnitude
    // ---------------------------------------------------------------
    logic               r2_valid;
    logic [2:0]         r2_neg;
    logic [31:0]        r2_m [3];
    logic signed [33:0] n2_s [3];
    logic [33:0]        n2_abs [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n2_s[a]   = 34'(r1_p[a][0]) + 34'(r1_p[a][1]) + 34'(r1_p[a][2]);
            n2_abs[a] = n2_s[a][33] ? 34'(-n2_s[a]) : 34'(n2_s[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r2_neg[a] <= n2_s[a][33];
                r2_m[a]   <= n2_abs[a][31:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // S3: largest magnitude, zero check
    // ---------------------------------------------------------------
    logic        r3_valid;
    logic [2:0]  r3_neg;
    logic        r3_zero;
    logic [31:0] r3_m [3];
    logic [31:0] r3_big;
    logic [31:0] n3_big;

    always_comb begin
        n3_big = r2_m[0];
        if (r2_m[1] > n3_big) n3_big = r2_m[1];
        if (r2_m[2] > n3_big) n3_big = r2_m[2];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_neg  <= r2_neg;
            r3_zero <= (r2_m[0] == '0) && (r2_m[1] == '0) && (r2_m[2] == '0);
            r3_m    <= r2_m;
            r3_big  <= n3_big;
        end
    end

    // ---------------------------------------------------------------
    // S4: leading one position of the largest magnitude
    // ---------------------------------------------------------------
    logic        r4_valid;
    logic [2:0]  r4_neg;
    logic        r4_zero;
    logic [31:0] r4_m [3];
    logic [4:0]  r4_pos;
    logic [4:0]  n4_pos;

    always_comb begin
        n4_pos = '0;
        for (int b = 0; b < 32; b++) begin
            if (r3_big[b]) n4_pos = 5'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
            r4_m    <= r3_m;
            r4_pos  <= n4_pos;
        end
    end

    // ---------------------------------------------------------------
    // S5: block scaling, right shifts truncate
    // ---------------------------------------------------------------
    logic        r5_valid;
    t_side       r5_side;
    logic [23:0] n5_mag [3];
    logic [31:0] n5_tmp [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r4_pos >= 5'(NORM_MSB)) begin
                n5_tmp[a] = r4_m[a] >> (r4_pos - 5'(NORM_MSB));
            end else begin
                n5_tmp[a] = r4_m[a] << (5'(NORM_MSB) - r4_pos);
            end
            n5_mag[a] = n5_tmp[a][23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side.neg  <= r4_neg;
            r5_side.zero <= r4_zero;
            for (int a = 0; a < 3; a++) begin
                r5_side.mag[a] <= n5_mag[a];
            end
        end
    end

    // ---------------------------------------------------------------
    // S6: squares
    // ---------------------------------------------------------------
    logic        r6_valid;
    t_side       r6_side;
    logic [47:0] r6_sq [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side <= r5_side;
            for (int a = 0; a < 3; a++) begin
                r6_sq[a] <= r5_side.mag[a] * r5_side.mag[a];
            end
        end
    end

    // ---------------------------------------------------------------
    // S7 (root stage 0): sum of squares, radicand = sum * 4096
    // ---------------------------------------------------------------
    logic        r_sq_valid [SQ_STEPS+1];
    t_side       r_sq_side  [SQ_STEPS+1];
    logic [61:0] r_sq_v     [SQ_STEPS+1];
    logic [32:0] r_sq_rem   [SQ_STEPS+1];
    logic [30:0] r_sq_root  [SQ_STEPS+1];
    logic [49:0] n7_sum;

    assign n7_sum = 50'(r6_sq[0]) + 50'(r6_sq[1]) + 50'(r6_sq[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_side[0] <= r6_side;
            r_sq_v[0]    <= {n7_sum, 12'd0};
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // restoring square root, one result bit per stage, radicand pairs from the top
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [34:0] rem_t;
        logic [34:0] trial;

        assign rem_t = {r_sq_rem[k], r_sq_v[k][61-2*k -: 2]};
        assign trial = {2'b00, r_sq_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_v[k+1]    <= r_sq_v[k];
                if (rem_t >= trial) begin
                    r_sq_rem[k+1]  <= 33'(rem_t - trial);
                    r_sq_root[k+1] <= {r_sq_root[k][29:0], 1'b1};
                end else begin
                    r_sq_rem[k+1]  <= rem_t[32:0];
                    r_sq_root[k+1] <= {r_sq_root[k][29:0], 1'b0};
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Divide stage 0: rounded numerators m * 2^21 + L/2
    // ---------------------------------------------------------------
    logic        r_dv_valid [DIV_STEPS+1];
    t_side       r_dv_side  [DIV_STEPS+1];
    logic [30:0] r_dv_len   [DIV_STEPS+1];
    logic [46:0] r_dv_rem   [DIV_STEPS+1][3];
    logic [16:0] r_dv_q     [DIV_STEPS+1][3];
    logic [30:0] len_f;

    assign len_f = r_sq_root[SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r_sq_side[SQ_STEPS];
            r_dv_len[0]  <= len_f;
            for (int a = 0; a < 3; a++) begin
                r_dv_rem[0][a] <= {r_sq_side[SQ_STEPS].mag[a], 21'd0}
                                + 47'(len_f[30:1]);
                r_dv_q[0][a]   <= '0;
            end
        end
    end

    // restoring division, quotient bit (DIV_STEPS-1-k) in stage k, three lanes
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int unsigned QB = DIV_STEPS - 1 - k;
        logic [47:0] dsor;

        assign dsor = 48'(r_dv_len[k]) << QB;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_side[k+1] <= r_dv_side[k];
                r_dv_len[k+1]  <= r_dv_len[k];
                for (int a = 0; a < 3; a++) begin
                    if ({1'b0, r_dv_rem[k][a]} >= dsor) begin
                        r_dv_rem[k+1][a] <= 47'({1'b0, r_dv_rem[k][a]} - dsor);
                        r_dv_q[k+1][a]   <= r_dv_q[k][a] | 17'(1 << QB);
                    end else begin
                        r_dv_rem[k+1][a] <= r_dv_rem[k][a];
                        r_dv_q[k+1][a]   <= r_dv_q[k][a];
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output: map to color, saturate; mid-gray for a zero normal
    // ---------------------------------------------------------------
    logic        r_out_valid;
    t_out_word   r_out_word;
    logic [15:0] n_chan [3];
    logic [16:0] d;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            d = r_dv_q[DIV_STEPS][a];
            if (r_dv_side[DIV_STEPS].zero) begin
                n_chan[a] = HALF_SCALE;
            end else if (r_dv_side[DIV_STEPS].neg[a]) begin
                n_chan[a] = (d >= 17'(HALF_SCALE)) ? 16'd0 : 16'(17'(HALF_SCALE) - d);
            end else begin
                n_chan[a] = (d >= 17'(HALF_SCALE)) ? CHAN_MAX : 16'(17'(HALF_SCALE) + d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_word.red        <= n_chan[0];
            r_out_word.green      <= n_chan[1];
            r_out_word.blue       <= n_chan[2];
            r_out_word.degenerate <= r_dv_side[DIV_STEPS].zero;
        end
    end

    // ---------------------------------------------------------------
    // Valid bits
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) r_sq_valid[k] <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) r_dv_valid[k] <= 1'b0;
        end else if (en) begin
            r1_valid      <= i_valid;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r4_valid      <= r3_valid;
            r5_valid      <= r4_valid;
            r6_valid      <= r5_valid;
            r_sq_valid[0] <= r6_valid;
            for (int k = 0; k < SQ_STEPS; k++) r_sq_valid[k+1] <= r_sq_valid[k];
            r_dv_valid[0] <= r_sq_valid[SQ_STEPS];
            for (int k = 0; k < DIV_STEPS; k++) r_dv_valid[k+1] <= r_dv_valid[k];
            r_out_valid   <= r_dv_valid[DIV_STEPS];
        end
    end

    // whole pipe holds while the output word is waiting
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for normal_interpolate_shade.
// Each pixel word sent is run through an in-bench fixed-point shading model.
// The model blends the normals, scales them, takes an integer square root and
// divides. Its color words queue in order, and every word leaving the block
// is compared with the oldest one.
// Directed corners come first, then random pixels under four idling phases.

module tb_top;
    import nis_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    normal_interpolate_shade uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_word  (in_word),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_word  (out_word)
    );

    localparam int PIPE_CYCLES = 57;
    localparam longint CYCLE_LIMIT = 400000;

    // Idle odds, in percent, for the sender and for the receiver.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    t_out_word   color_q[$];
    int unsigned error_count;
    longint      cycle_count = 0;

    always begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // Integer square root, bit by bit (floor).
    function automatic logic [63:0] root_floor(input logic [63:0] radicand);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > radicand) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (radicand >= res + bitv) begin
                radicand = radicand - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_out_word shade_pixel(input t_in_word px);
        t_out_word   c;
        logic signed [15:0] wt[3];
        logic signed [15:0] nv[3][3];
        logic signed [63:0] blend;
        logic [63:0] mag[3];
        logic        neg[3];
        logic [63:0] peak;
        logic [63:0] len;
        logic [63:0] unit;
        logic [63:0] chan;
        wt = '{px.weight_a, px.weight_b, px.weight_c};
        nv[0] = '{px.normal_a_x, px.normal_a_y, px.normal_a_z};
        nv[1] = '{px.normal_b_x, px.normal_b_y, px.normal_b_z};
        nv[2] = '{px.normal_c_x, px.normal_c_y, px.normal_c_z};
        for (int ax = 0; ax < 3; ax++) begin
            blend = 0;
            for (int vx = 0; vx < 3; vx++)
                blend += 64'(wt[vx]) * 64'(nv[vx][ax]);
            neg[ax] = blend < 0;
            mag[ax] = neg[ax] ? -blend : blend;
        end
        // Zero-length blended normal: flag it and send mid-gray.
        if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
            c.red = HALF_SCALE;
            c.green = HALF_SCALE;
            c.blue = HALF_SCALE;
            c.degenerate = 1'b1;
            return c;
        end
        peak = mag[0];
        if (mag[1] > peak) peak = mag[1];
        if (mag[2] > peak) peak = mag[2];
        while (peak >= (64'd1 << 24)) begin
            peak >>= 1;
            for (int ax = 0; ax < 3; ax++) mag[ax] >>= 1;
        end
        while (peak < (64'd1 << 23)) begin
            peak <<= 1;
            for (int ax = 0; ax < 3; ax++) mag[ax] <<= 1;
        end
        len = root_floor((mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2]) << 12);
        for (int ax = 0; ax < 3; ax++) begin
            unit = ((mag[ax] << 21) + (len >> 1)) / len;
            if (neg[ax])
                chan = (unit >= 32768) ? 0 : 32768 - unit;
            else
                chan = (32768 + unit > 65535) ? 65535 : 32768 + unit;
            if (ax == 0) c.red = chan[15:0];
            else if (ax == 1) c.green = chan[15:0];
            else c.blue = chan[15:0];
        end
        c.degenerate = 1'b0;
        return c;
    endfunction

    // Hand one word to the block; drive at falling edges, accept at rising.
    // Valid stays up after the word is taken; an idle turn in the next call or a drain drops it.
    task automatic send_pixel(input t_in_word px);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        color_q.push_back(shade_pixel(px));
        @(negedge clk);
    endtask

    function automatic t_in_word rand_pixel();
        t_in_word px;
        px = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return px;
    endfunction

    // Random normals, weights summing to 1.0 (Q2.14 = 16384).
    function automatic t_in_word plausible_pixel();
        t_in_word px;
        int wa;
        int wb;
        px = rand_pixel();
        wa = $urandom_range(16384);
        wb = $urandom_range(16384 - wa);
        px.weight_a = 16'(wa);
        px.weight_b = 16'(wb);
        px.weight_c = 16'(16384 - wa - wb);
        return px;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (color_q.size() != 0) @(negedge clk);
    endtask

    // Receiver stalls at random; checker runs at each rising edge.
    always @(negedge clk) begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        t_out_word want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall) begin
            if (color_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, out_word);
                error_count++;
            end else begin
                want = color_q.pop_front();
                if (out_word.red !== want.red)
                    $display("%0t: red expected %h actual %h", $time, want.red, out_word.red);
                if (out_word.green !== want.green)
                    $display("%0t: green expected %h actual %h",
                             $time, want.green, out_word.green);
                if (out_word.blue !== want.blue)
                    $display("%0t: blue expected %h actual %h",
                             $time, want.blue, out_word.blue);
                if (out_word.degenerate !== want.degenerate)
                    $display("%0t: degenerate expected %b actual %b",
                             $time, want.degenerate, out_word.degenerate);
                if (out_word !== want) error_count++;
            end
        end
    end

    always @(posedge clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic test_corners();
        t_in_word px;
        // all zero: degenerate
        px = '0;
        send_pixel(px);
        // nonzero weights but normals cancel: degenerate
        px = '0;
        px.weight_a = 16'sd16384; px.weight_b = 16'sd16384;
        px.normal_a_x = 16'sd1000; px.normal_b_x = -16'sd1000;
        send_pixel(px);
        // all most negative: largest products
        px = {12{16'h8000}};
        send_pixel(px);
        // all most positive
        px = {12{16'h7fff}};
        send_pixel(px);
        // mixed extremes per axis
        px = {16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff, 16'h0000,
              16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'hffff, 16'h8000};
        send_pixel(px);
        // tiny sum: large left shift
        px = '0;
        px.weight_c = 16'sd1; px.normal_c_z = -16'sd1;
        send_pixel(px);
        // single axis both signs: saturates to 65535 and 0
        px = '0;
        px.weight_a = 16'sd16384; px.normal_a_y = 16'sd32767;
        send_pixel(px);
        px.normal_a_y = 16'sh8000;
        send_pixel(px);
        // all ones pattern
        px = {12{16'hffff}};
        send_pixel(px);
        for (int k = 0; k < 8; k++) send_pixel(plausible_pixel());
    endtask

    task automatic test_random(input int unsigned count);
        for (int k = 0; k < count; k++)
            send_pixel(($urandom_range(3) == 0) ? rand_pixel() : plausible_pixel());
    endtask

    // Let the pipe fully drain with the sender held off.
    task automatic test_drain_pause();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial begin
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        cycle_count = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_corners();
        test_random(100);
        send_idle_pct = 51;
        test_random(90);
        send_idle_pct = 0;
        recv_stall_pct = 51;
        test_random(90);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        test_random(90);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_drain_pause();

        wait_drained();
        repeat (PIPE_CYCLES + 10) @(negedge clk);
        if (error_count == 0 && color_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

>>> normal_interpolate_shade.f
src/nis_pkg.sv
src/normal_interpolate_shade.sv
test/tb_top.sv
